// ===== hdl/cldf_pkg.sv =====
// Package for the content-length message deframer.
// Holds the parser state enums, the queue item type and the header name table.
// No dependencies.
`default_nettype none

package cldf_pkg;

  localparam int unsigned LEN_W    = 31;
  localparam int unsigned NAME_LEN = 14;

  localparam logic [LEN_W-1:0] MAX_BODY_RESET = 31'd1048576;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_HEAD,
    PH_BODY,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    LS_LEAD,
    LS_NAME,
    LS_TRAIL,
    LS_VLEAD,
    LS_DIGITS,
    LS_DONE,
    LS_BAD
  } line_step_t;

  typedef enum logic [1:0] {
    BT_START,
    BT_CR,
    BT_OTHER
  } blank_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cldf_item_t;

  typedef struct packed {
    logic       valid;
    cldf_item_t item;
  } cldf_push_t;

  typedef struct packed {
    phase_t phase;
    logic   rem_zero;
  } cldf_front_status_t;

  // Lower-case "content-length", one character per position.
  function automatic logic [7:0] name_at(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h6C; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cldf_front.sv =====
// Front end of the deframer: accepts stream bytes, runs the header parser
// and body counter, and pushes body bytes into the queue. Uses cldf_pkg.
`default_nettype none

module cldf_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [7:0]                  in_byte,
  input  wire logic                        cfg_wr_en,
  input  wire logic [cldf_pkg::LEN_W-1:0]  cfg_wr_data,
  input  wire logic                        q_full,
  output cldf_pkg::cldf_push_t             push,
  output cldf_pkg::cldf_front_status_t     status
);
  import cldf_pkg::*;

  phase_t           phase_r, phase_nxt;
  line_step_t       step_r, step_nxt;
  blank_t           blank_r, blank_nxt;
  logic [3:0]       npos_r, npos_nxt;
  logic [LEN_W-1:0] sum_r, sum_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] max_r;

  logic        accept;
  logic        is_blank;
  logic        is_digit;
  logic [7:0]  folded;
  logic        name_hit;
  logic [34:0] sum_x10;
  logic        rem_last;

  assign accept   = in_valid && !q_full;
  assign is_blank = in_byte inside {CH_SPACE, CH_TAB};
  assign is_digit = in_byte inside {[8'h30:8'h39]};
  assign folded   = (in_byte inside {[8'h41:8'h5A]}) ? (in_byte + 8'd32) : in_byte;
  assign name_hit = (npos_r < 4'(NAME_LEN)) && (folded == name_at(npos_r));
  // sum*10 + digit as (sum<<3) + (sum<<1) + digit
  assign sum_x10  = ({4'b0, sum_r} << 3) + ({4'b0, sum_r} << 1) + {31'b0, in_byte[3:0]};
  assign rem_last = (rem_r <= 31'd1);

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    blank_nxt = blank_r;
    npos_nxt  = npos_r;
    sum_nxt   = sum_r;
    ovf_nxt   = ovf_r;
    rem_nxt   = rem_r;
    if (accept) begin
      case (phase_r)
        PH_BODY, PH_SKIP: begin
          rem_nxt = (rem_r != '0) ? rem_r - 31'd1 : '0;
          if (rem_last) begin
            rem_nxt   = '0;
            phase_nxt = PH_SEEK;
            step_nxt  = LS_LEAD;
            npos_nxt  = '0;
            sum_nxt   = '0;
            ovf_nxt   = 1'b0;
            blank_nxt = BT_START;
          end
        end
        PH_HEAD: begin
          if (in_byte == CH_LF) begin
            if (blank_r == BT_START || blank_r == BT_CR) begin
              rem_nxt   = sum_r;
              phase_nxt = (sum_r > max_r) ? PH_SKIP : PH_BODY;
              if (sum_r == '0) begin
                phase_nxt = PH_SEEK;
                step_nxt  = LS_LEAD;
                npos_nxt  = '0;
                sum_nxt   = '0;
                ovf_nxt   = 1'b0;
              end
            end else begin
              blank_nxt = BT_START;
            end
          end else if (in_byte == CH_CR && blank_r == BT_START) begin
            blank_nxt = BT_CR;
          end else begin
            blank_nxt = BT_OTHER;
          end
        end
        default: begin
          if (in_byte == CH_LF) begin
            if ((step_r == LS_DIGITS || step_r == LS_DONE) && !ovf_r && sum_r != '0) begin
              phase_nxt = PH_HEAD;
              blank_nxt = BT_START;
              step_nxt  = LS_LEAD;
              npos_nxt  = '0;
            end else begin
              step_nxt = LS_LEAD;
              npos_nxt = '0;
              sum_nxt  = '0;
              ovf_nxt  = 1'b0;
            end
          end else begin
            case (step_r)
              LS_LEAD: begin
                if (!is_blank) begin
                  if (in_byte == CH_COLON) begin
                    step_nxt = LS_BAD;
                  end else if (name_hit) begin
                    npos_nxt = npos_r + 4'd1;
                    step_nxt = LS_NAME;
                  end else begin
                    step_nxt = LS_BAD;
                  end
                end
              end
              LS_NAME: begin
                if (in_byte == CH_COLON) begin
                  step_nxt = (npos_r == 4'(NAME_LEN)) ? LS_VLEAD : LS_BAD;
                end else if (is_blank) begin
                  step_nxt = (npos_r == 4'(NAME_LEN)) ? LS_TRAIL : LS_BAD;
                end else if (name_hit) begin
                  npos_nxt = npos_r + 4'd1;
                end else begin
                  step_nxt = LS_BAD;
                end
              end
              LS_TRAIL: begin
                if (in_byte == CH_COLON) begin
                  step_nxt = LS_VLEAD;
                end else if (!is_blank) begin
                  step_nxt = LS_BAD;
                end
              end
              LS_VLEAD: begin
                if (is_digit) begin
                  sum_nxt  = {27'b0, in_byte[3:0]};
                  step_nxt = LS_DIGITS;
                end else if (!is_blank) begin
                  step_nxt = LS_BAD;
                end
              end
              LS_DIGITS: begin
                if (is_digit) begin
                  if (ovf_r || sum_x10 > 35'h7FFF_FFFF) begin
                    ovf_nxt = 1'b1;
                    sum_nxt = '0;
                  end else begin
                    sum_nxt = sum_x10[LEN_W-1:0];
                  end
                end else begin
                  step_nxt = LS_DONE;
                end
              end
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    push.valid     = accept && (phase_r == PH_BODY);
    push.item.data = in_byte;
    push.item.last = rem_last;
    status.phase    = phase_r;
    status.rem_zero = (rem_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      step_r  <= LS_LEAD;
      blank_r <= BT_START;
      npos_r  <= '0;
      sum_r   <= '0;
      ovf_r   <= 1'b0;
      rem_r   <= '0;
      max_r   <= MAX_BODY_RESET;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      blank_r <= blank_nxt;
      npos_r  <= npos_nxt;
      sum_r   <= sum_nxt;
      ovf_r   <= ovf_nxt;
      rem_r   <= rem_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cldf_queue.sv =====
// Short FIFO between front and back of the deframer.
// Flip-flop storage, head item read at the read pointer. Uses cldf_pkg.
`default_nettype none

module cldf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cldf_pkg::cldf_push_t  push,
  input  wire logic                  pop,
  output logic                       full,
  output logic                       empty,
  output cldf_pkg::cldf_item_t       head
);
  import cldf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cldf_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cldf_back.sv =====
// Back end of the deframer: pulls items from the queue into the output
// register and hands them to the result channel. Uses cldf_pkg.
`default_nettype none

module cldf_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_empty,
  input  wire cldf_pkg::cldf_item_t  q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_body_byte,
  output logic                       out_body_last
);
  import cldf_pkg::*;

  logic       valid_r, valid_nxt;
  cldf_item_t item_r;

  // Reload whenever the register is empty or being taken this cycle.
  assign q_pop = !q_empty && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_head;
    end
  end

  assign out_valid     = valid_r;
  assign out_body_byte = item_r.data;
  assign out_body_last = item_r.last;

endmodule

`default_nettype wire

// ===== hdl/content_length_message_deframer_unit.sv =====
// Top level of the content-length message deframer.
// Instantiates cldf_front, cldf_queue and cldf_back; uses cldf_pkg.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_byte[7:0]
//   out_     output     out_valid/out_stall  out_body_byte[7:0], out_body_last
//   cfg_     input      cfg_wr_en            cfg_wr_data[30:0] (max_body_bytes)
//
// One input item per cycle while in_stall is low; the parser updates its state in the
// cycle the item is accepted (one shift-add accumulate for the length digits).
// A body byte is written into the queue when its input item is accepted, then
// loads from the queue into the output register, which drives out_valid.
// Synchronous active-low reset; no clearing pass, ready right after reset.
// in_stall rises only when the queue is full, i.e. after out_stall has held
// the output register for QUEUE_DEPTH or more items.
`default_nettype none

module content_length_message_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input stream
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_byte,
  // body bytes
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       out_body_byte,
  output logic                             out_body_last,
  // max_body_bytes register
  input  wire logic                        cfg_wr_en,
  input  wire logic [cldf_pkg::LEN_W-1:0]  cfg_wr_data
);
  import cldf_pkg::*;

  cldf_push_t         push;
  cldf_front_status_t front_status;
  cldf_item_t         q_head;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;

  // Front stalls only on a full queue; bytes that produce no item still
  // wait, which keeps the stall independent of the byte's class.
  assign in_stall = q_full;

  cldf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_byte     (in_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push        (push),
    .status      (front_status)
  );

  cldf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  cldf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_body_byte (out_body_byte),
    .out_body_last (out_body_last)
  );

  // While a body is being passed or skipped, the byte count never sits at zero.
  a_body_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (front_status.phase == PH_BODY || front_status.phase == PH_SKIP)
      |-> !front_status.rem_zero)
    else $error("body phase with zero bytes remaining");

  // The last body byte sends the parser back to seeking a header.
  a_last_ends_body: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && push.item.last) |=> (front_status.phase == PH_SEEK))
    else $error("parser did not resync after last body byte");

  // The front never pushes into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !q_full)
    else $error("push into full queue");

endmodule

`default_nettype wire

// ===== dv/content_length_message_deframer_unit_tb.sv =====
// Self-checking testbench for content_length_message_deframer_unit.
// Drives a raw byte stream of framed and broken messages, predicts the body items
// in a local deframer copy and checks every output item; depends on cldf_pkg and the RTL.
`default_nettype none

module content_length_message_deframer_unit_tb;
  import cldf_pkg::*;

  // timing knobs
  localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles with no handshake at all
  localparam int unsigned DRAIN_CYCLES   = 4;    // queue + output register, with margin
  localparam int unsigned IDLE_PCT       = 21;
  localparam int unsigned CALM_FROM      = 700;  // accepted-byte window without idling
  localparam int unsigned CALM_TO        = 1000;
  localparam int unsigned RANDOM_BYTES   = 180;  // per random phase

  // characters the deframer cares about beyond the package set
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [8*NAME_LEN-1:0] HDR_NAME = "content-length";
  localparam longint unsigned LEN_LIMIT = 64'h7FFF_FFFF;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_byte;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_body_byte;
  logic             out_body_last;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  content_length_message_deframer_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_body_byte(out_body_byte),
    .out_body_last(out_body_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // stream bytes waiting for the driver, and body items waiting for the DUT
  logic [7:0]  byte_q[$];
  cldf_item_t  body_q[$];
  cldf_item_t  body_want;
  int unsigned bytes_queued;
  int unsigned bytes_taken;
  int unsigned fault_count;
  int unsigned quiet_cycles;
  logic        in_took;

  // ---------------------------------------------------------------------------
  // Deframer prediction: own copy of the parser state and the length limit.
  // ---------------------------------------------------------------------------
  phase_t           fr_phase;
  line_step_t       fr_step;
  logic [3:0]       fr_name_pos;
  logic [LEN_W-1:0] fr_len;
  logic             fr_len_ovf;
  blank_t           fr_blank;
  logic [LEN_W-1:0] fr_left;
  logic [LEN_W-1:0] fr_max;

  function automatic bit is_gap(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB;
  endfunction

  function automatic bit is_num(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  task automatic clear_line();
    fr_step     = LS_LEAD;
    fr_name_pos = '0;
    fr_len      = '0;
    fr_len_ovf  = 1'b0;
  endtask

  // one name character, compared case-folded against "content-length"
  task automatic match_name(input logic [7:0] b);
    logic [7:0] lc;
    lc = (b >= CH_UP_A && b <= CH_UP_Z) ? b + 8'd32 : b;
    if (fr_name_pos < NAME_LEN &&
        lc == HDR_NAME[8*(NAME_LEN-1-fr_name_pos) +: 8]) begin
      fr_name_pos = fr_name_pos + 4'd1;
      fr_step     = LS_NAME;
    end else begin
      fr_step = LS_BAD;
    end
  endtask

  // a byte while hunting for a length header line
  task automatic scan_line_byte(input logic [7:0] b);
    longint unsigned acc;
    if (b == CH_LF) begin
      if ((fr_step == LS_DIGITS || fr_step == LS_DONE) && !fr_len_ovf && fr_len != '0) begin
        fr_phase    = PH_HEAD;
        fr_blank    = BT_START;
        fr_step     = LS_LEAD;
        fr_name_pos = '0;
      end else begin
        clear_line();
      end
    end else begin
      case (fr_step)
        LS_LEAD: begin
          if (!is_gap(b)) begin
            if (b == CH_COLON) fr_step = LS_BAD;
            else match_name(b);
          end
        end
        LS_NAME: begin
          if (b == CH_COLON) fr_step = (fr_name_pos == NAME_LEN) ? LS_VLEAD : LS_BAD;
          else if (is_gap(b)) fr_step = (fr_name_pos == NAME_LEN) ? LS_TRAIL : LS_BAD;
          else match_name(b);
        end
        LS_TRAIL: begin
          if (b == CH_COLON) fr_step = LS_VLEAD;
          else if (!is_gap(b)) fr_step = LS_BAD;
        end
        LS_VLEAD: begin
          if (is_num(b)) begin
            fr_len  = LEN_W'(b - CH_ZERO);
            fr_step = LS_DIGITS;
          end else if (!is_gap(b)) begin
            fr_step = LS_BAD;
          end
        end
        LS_DIGITS: begin
          if (is_num(b)) begin
            acc = fr_len;
            acc = acc * 10 + (b - CH_ZERO);
            if (fr_len_ovf || acc > LEN_LIMIT) begin
              fr_len_ovf = 1'b1;
              fr_len     = '0;
            end else begin
              fr_len = acc[LEN_W-1:0];
            end
          end else begin
            fr_step = LS_DONE;
          end
        end
        default: ; // done or bad: rest of line ignored
      endcase
    end
  endtask

  // full step for one accepted input byte; pushes the body item it yields
  task automatic deframe_byte(input logic [7:0] b);
    cldf_item_t item;
    bit         at_end;
    case (fr_phase)
      PH_BODY, PH_SKIP: begin
        at_end = (fr_left <= 1);
        if (fr_left != '0) fr_left = fr_left - 1'b1;
        if (fr_phase == PH_BODY) begin
          item.data = b;
          item.last = at_end;
          body_q.push_back(item);
        end
        if (at_end) begin
          fr_left  = '0;
          fr_phase = PH_SEEK;
          clear_line();
          fr_blank = BT_START;
        end
      end
      PH_HEAD: begin
        // header block: wait for an empty line, LF alone or CR LF
        if (b == CH_LF) begin
          if (fr_blank == BT_START || fr_blank == BT_CR) begin
            fr_left  = fr_len;
            fr_phase = (fr_len > fr_max) ? PH_SKIP : PH_BODY;
            if (fr_left == '0) begin
              fr_phase = PH_SEEK;
              clear_line();
            end
          end else begin
            fr_blank = BT_START;
          end
        end else if (b == CH_CR && fr_blank == BT_START) begin
          fr_blank = BT_CR;
        end else begin
          fr_blank = BT_OTHER;
        end
      end
      default: scan_line_byte(b);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers: everything goes through push_byte.
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic end_line();
    if ($urandom_range(0, 1) == 1) push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic push_line(input string s);
    push_text(s);
    end_line();
  endtask

  task automatic push_gaps(input int unsigned n);
    repeat (n) push_byte(($urandom_range(0, 1) == 1) ? CH_TAB : CH_SPACE);
  endtask

  task automatic push_body(input int unsigned n);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
  endtask

  // length header with random letter case, blanks, leading zeros and a tail
  task automatic push_length_line(input int unsigned len);
    string nm;
    nm = "content-length";
    for (int k = 0; k < nm.len(); k++) begin
      if (nm[k] >= "a" && nm[k] <= "z" && $urandom_range(0, 1) == 1) nm[k] = nm[k] - 8'd32;
    end
    push_gaps($urandom_range(0, 2));
    push_text(nm);
    push_gaps($urandom_range(0, 2));
    push_byte(CH_COLON);
    push_gaps($urandom_range(0, 3));
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0) push_byte(CH_ZERO);
    push_text($sformatf("%0d", len));
    if ($urandom_range(0, 4) == 0) push_text("; v=2");
    end_line();
  endtask

  // a whole frame (header block, blank line, body)
  task automatic push_frame(input int unsigned len);
    push_length_line(len);
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: push_length_line($urandom_range(1, 99)); // ignored inside the block
        1: push_line("Content-Type: text/plain");
        2: begin                                     // CR CR LF is not blank
          push_byte(CH_CR);
          push_byte(CH_CR);
          push_byte(CH_LF);
        end
        default: begin
          push_gaps($urandom_range(1, 2));
          end_line();
        end
      endcase
    end
    push_line("");
    push_body(len);
  endtask

  task automatic push_random_frame();
    int unsigned len;
    string       nm;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    if ($urandom_range(0, 99) < 78) begin
      if ($urandom_range(0, 3) == 0) push_line("Accept: */*");
      push_frame(len);
    end else begin
      case ($urandom_range(0, 4))
        0: begin // raw noise
          repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
          push_byte(CH_LF);
        end
        1: begin // one name character damaged
          nm = "content-length";
          nm[$urandom_range(0, NAME_LEN - 1)] = 8'($urandom_range(1, 255));
          push_text(nm);
          push_text($sformatf(": %0d", len));
          end_line();
        end
        2: begin // value that must be refused
          push_text("content-length:");
          case ($urandom_range(0, 7))
            0: push_text("");
            1: push_text(" -5");
            2: push_text(" +5");
            3: push_text(" x5");
            4: push_text(" 0");
            5: push_text(" 000");
            6: push_text(" 2147483648");
            default: push_text(" 99999999999");
          endcase
          end_line();
        end
        3: push_line("content-length 5"); // no colon
        default: begin                    // line cut short
          push_text("Content-Le");
          push_byte(CH_LF);
        end
      endcase
    end
  endtask

  task automatic push_random_phase();
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < RANDOM_BYTES) push_random_frame();
  endtask

  // wait until every byte went in and every body item came out
  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid || body_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [LEN_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    fr_max       = v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic bit no_idle();
    return bytes_taken >= CALM_FROM && bytes_taken < CALM_TO;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: presents the next byte at the falling edge; a stalled byte holds.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (byte_q.size() != 0 && (no_idle() || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_byte  <= byte_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure, also at the falling edge
  always @(negedge clk) begin
    out_stall <= rst_n && !no_idle() && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // input tap: every accepted byte runs through the prediction
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      deframe_byte(in_byte);
      bytes_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each accepted body item against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (body_q.size() == 0) begin
        $display("%0t: unexpected body item: expected none, actual byte %02h last %0b",
                 $time, out_body_byte, out_body_last);
        fault_count++;
      end else begin
        body_want = body_q.pop_front();
        if (out_body_byte !== body_want.data) begin
          $display("%0t: body byte mismatch: expected %02h, actual %02h",
                   $time, body_want.data, out_body_byte);
          fault_count++;
        end
        if (out_body_last !== body_want.last) begin
          $display("%0t: body last mismatch: expected %0b, actual %0b",
                   $time, body_want.last, out_body_last);
          fault_count++;
        end
      end
    end
  end

  // watchdog: too long without any handshake means the DUT hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("content_length_message_deframer_unit_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases; the length limit only changes while the DUT is idle.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned lim;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte      = '0;
    out_stall    = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_took      = 1'b0;
    bytes_queued = 0;
    bytes_taken  = 0;
    fault_count  = 0;
    quiet_cycles = 0;
    fr_phase     = PH_SEEK;
    clear_line();
    fr_blank     = BT_START;
    fr_left      = '0;
    fr_max       = MAX_BODY_RESET;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, limit at its reset value
    push_line("Content-Length: 3"); // body carries 00, FF and a LF
    push_line("");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_LF);
    push_line(" \tcontent-length \t:\t 5;q=1"); // blanks trimmed, tail after digits ignored
    push_line("X-Other: 1");
    push_line("content-length: 9"); // second length header in the block, ignored
    push_byte(CH_CR);               // CR CR line does not end the block
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_line("");
    push_body(5);
    // lines that must all be dropped
    push_line("content-length 4");
    push_line(": 4");
    push_line("  : 4");
    push_line("Content-Type: 4");
    push_line("content-length:");
    push_line("content-length: -4");
    push_line("content-length: +4");
    push_line("content-length: x4");
    push_line("content-length: 0");
    push_line("content-length: 000");
    push_line("content-length: 2147483648");
    push_line("content-length: 99999999999");
    push_line("content-lengthh: 4");
    push_line("content le: 4");
    push_line("");
    // upper case, leading zeros, one-byte body, LF-only blank line
    push_text("CONTENT-LENGTH:0000000001");
    push_byte(CH_LF);
    push_byte(CH_LF);
    push_body(1);
    push_line("content-length:\t12");
    push_line("");
    push_body(12);
    wait_idle();

    // limit zero: every body skipped
    write_max_len('0);
    push_frame(1);
    push_frame(12);
    push_random_phase();
    wait_idle();

    // limit at its top: nothing skipped
    write_max_len('1);
    push_frame(12);
    push_random_phase();
    wait_idle();

    // small limit: bodies right at it and one above it
    lim = $urandom_range(1, 8);
    write_max_len(LEN_W'(lim));
    push_frame(lim);
    push_frame(lim + 1);
    push_random_phase();
    wait_idle();

    // back to the reset value
    write_max_len(MAX_BODY_RESET);
    push_random_phase();
    wait_idle();

    fault_count += body_q.size();
    if (fault_count == 0) begin
      $display("content_length_message_deframer_unit_tb passed");
    end else begin
      $display("content_length_message_deframer_unit_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/cldf_pkg.sv
hdl/cldf_front.sv
hdl/cldf_queue.sv
hdl/cldf_back.sv
hdl/content_length_message_deframer_unit.sv
dv/content_length_message_deframer_unit_tb.sv
